/* rtl/core/i2p_pkg.sv */
// Shared types, character codes and helper functions for the infix to postfix converter.
// No dependencies.
package i2p_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int CHAR_W          = 8;

    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef logic signed [2:0] t_prec;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OPS,
        ST_CLOSE,
        ST_FLUSH
    } t_state;

    function automatic t_prec prec_of(input logic [CHAR_W-1:0] c);
        t_prec p;
        if (c == CH_STAR || c == CH_SLASH) begin
            p = 3'sd2;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            p = 3'sd1;
        end else begin
            p = -3'sd1;
        end
        return p;
    endfunction

    function automatic logic is_hex(input logic [CHAR_W-1:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    // True when stacked entry t is popped ahead of an incoming operator of precedence p.
    function automatic logic pops_ahead(input logic [CHAR_W-1:0] t, input t_prec p);
        return (t != CH_OPEN) && (prec_of(t) >= p);
    endfunction

endpackage

/* rtl/core/infix_to_postfix_converter_core.sv */
// Top level of the infix to postfix converter: stream ports, control sequencer, output register.
// Depends on i2p_pkg and i2p_stack.
//
// Takes one infix character per item and produces postfix characters by the shunting-yard
// method with left associativity. Operators wait in a row of shifting cells (STACK_DEPTH
// entries); each popped operator gives one result. Spaces are dropped, hex digits pass to the
// output and '(' is pushed; an operator emits a space, pops the entries that go ahead of it
// and is pushed; ')' pops up to its '(', which is dropped; an end item pops every stacked
// entry and ends with a zero byte marked tlast. Input is taken only while no item is in work
// and the output register can load. A push onto a full stack is dropped and sets the overflow
// flag in tuser, which the end item reports and clears.
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_char
    input  logic [0:0] i_s_tuser,   // [0] end_of_expr
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_char
    output logic       o_m_tlast,
    output logic [0:0] o_m_tuser    // [0] overflow
);
    import i2p_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state            r_state, n_state;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_ovf, n_ovf;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_data, n_out_data;
    logic              r_out_last, n_out_last;
    logic              r_out_ovf, n_out_ovf;

    t_stk_op           w_op;
    logic [CHAR_W-1:0] w_push_data;
    logic [CHAR_W-1:0] w_top, w_next;
    logic [CW-1:0]     w_count;
    logic              w_out_free, w_full, w_accept;
    logic              w_first_pops, w_top_pops, w_next_pops;

    i2p_stack #(.DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_data  (w_push_data),
        .o_top   (w_top),
        .o_next  (w_next),
        .o_count (w_count)
    );

    assign w_out_free   = !r_out_valid || i_m_tready;
    assign w_full       = (w_count == CW'(STACK_DEPTH));
    assign o_s_tready   = (r_state == ST_IDLE) && w_out_free;
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_first_pops = (w_count != '0) && pops_ahead(w_top, prec_of(i_s_tdata));
    assign w_top_pops   = (w_count != '0) && pops_ahead(w_top, prec_of(r_char));
    assign w_next_pops  = (w_count > CW'(1)) && pops_ahead(w_next, prec_of(r_char));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    always_comb begin
        n_state     = r_state;
        n_char      = r_char;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        w_op        = '0;
        w_push_data = r_char;

        case (r_state)
            ST_IDLE: begin
                w_push_data = i_s_tdata;
                if (w_accept) begin
                    if (i_s_tuser[0]) begin
                        n_state = ST_FLUSH;
                    end else if (i_s_tdata == CH_SPACE) begin
                        n_state = ST_IDLE;
                    end else if (is_hex(i_s_tdata)) begin
                        n_out_valid = 1'b1;
                        n_out_data  = i_s_tdata;
                        n_out_last  = 1'b1;
                        n_out_ovf   = r_ovf;
                    end else if (i_s_tdata == CH_OPEN) begin
                        if (w_full) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_op.push = 1'b1;
                        end
                    end else if (i_s_tdata == CH_CLOSE) begin
                        n_state = ST_CLOSE;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_data  = CH_SPACE;
                        n_out_last  = !w_first_pops;
                        n_out_ovf   = r_ovf;
                        n_char      = i_s_tdata;
                        n_state     = ST_OPS;
                    end
                end
            end
            ST_OPS: begin
                if (w_top_pops) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = w_top;
                        n_out_last  = !w_next_pops;
                        n_out_ovf   = r_ovf;
                        w_op.pop    = 1'b1;
                    end
                end else begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_op.push = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_CLOSE: begin
                if (w_count == '0) begin
                    n_state = ST_IDLE;
                end else if (w_top == CH_OPEN) begin
                    w_op.pop = 1'b1;
                    n_state  = ST_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_top;
                    n_out_last  = (w_count == CW'(1)) || (w_next == CH_OPEN);
                    n_out_ovf   = r_ovf;
                    w_op.pop    = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ovf   = r_ovf;
                    if (w_count != '0) begin
                        n_out_data = w_top;
                        n_out_last = 1'b0;
                        w_op.pop   = 1'b1;
                    end else begin
                        n_out_data = CH_NUL;
                        n_out_last = 1'b1;
                        n_ovf      = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tlast    = r_out_last;
    assign o_m_tuser[0] = r_out_ovf;

endmodule

/* rtl/core/i2p_cell.sv */
// One stack cell: holds one entry, shifts down on push and up on pop.
// Depends on i2p_pkg.
module i2p_cell (
    input  logic                  i_clk,
    input  i2p_pkg::t_stk_op      i_op,
    input  logic [7:0]            i_from_above,
    input  logic [7:0]            i_from_below,
    output logic [7:0]            o_val
);
    import i2p_pkg::*;

    logic [CHAR_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_val <= i_from_above;
        end else if (i_op.pop) begin
            r_val <= i_from_below;
        end
    end

    assign o_val = r_val;

endmodule

/* rtl/core/i2p_stack.sv */
// Operator stack built as a row of shifting cells with an entry count; cell 0 is the top.
// Depends on i2p_pkg and i2p_cell.
module i2p_stack #(
    parameter int DEPTH = i2p_pkg::STACK_DEPTH_DEF,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  i2p_pkg::t_stk_op      i_op,
    input  logic [7:0]            i_data,
    output logic [7:0]            o_top,
    output logic [7:0]            o_next,
    output logic [CW-1:0]         o_count
);
    import i2p_pkg::*;

    logic [CHAR_W-1:0] w_val [DEPTH];
    logic [CW-1:0]     r_count;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [CHAR_W-1:0] w_above;
        logic [CHAR_W-1:0] w_below;
        if (k == 0) begin : g_first
            assign w_above = i_data;
        end else begin : g_mid
            assign w_above = w_val[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_below = w_val[k];
        end else begin : g_inner
            assign w_below = w_val[k+1];
        end
        i2p_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (i_op),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_val        (w_val[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_op.push) begin
            r_count <= r_count + CW'(1);
        end else if (i_op.pop) begin
            r_count <= r_count - CW'(1);
        end
    end

    assign o_top   = w_val[0];
    assign o_next  = w_val[1];
    assign o_count = r_count;

endmodule
